// ----- rtl/cdo_pkg.sv -----
// Shared types, constants and calendar tables for the civil date offset block.
package cdo_pkg;

    // Stream widths: fields packed from bit 0 up, padded to whole bytes.
    localparam int IN_W  = 40;
    localparam int OUT_W = 48;

    // Day count of the internal base: days from 1970-01-01 plus 719468 plus one
    // whole 400-year era, so every reachable count is positive.
    localparam int DAY_W = 23;

    // Days in a 400-year era.
    localparam logic [17:0] ERA_DAYS = 18'd146097;

    // Reciprocals for division by constants (multiply, then shift).
    localparam logic [14:0] ERA_RECIP  = 15'd29398;    // 2^32 / 146097, rounded down
    localparam logic [23:0] WEEK_RECIP = 24'd9586981;  // 2^26 / 7, rounded up
    localparam logic [17:0] Q1460_RECIP = 18'd183860;  // 2^28 / 1460, rounded up
    localparam logic [17:0] YEAR_RECIP = 18'd183860;   // 2^26 / 365, rounded up
    localparam logic [12:0] Q25_RECIP  = 13'd5243;     // 2^17 / 25, rounded up

    // Internal day count of 2019-05-01, first day of the Reiwa era.
    localparam logic [DAY_W-1:0] REIWA_DAY = 23'd883582;

    // Day-of-year (March based) of the first day of each month, indexed by the
    // input month code 0..15 so that codes outside 1..12 run on linearly.
    localparam logic [8:0] MONTH_BASE [16] = '{
        9'd275, 9'd306, 9'd337, 9'd0,   9'd31,  9'd61,  9'd92,  9'd122,
        9'd153, 9'd184, 9'd214, 9'd245, 9'd275, 9'd306, 9'd337, 9'd367
    };

    // Day-of-year (March based) where each month starts, March first.
    localparam logic [8:0] MONTH_START [12] = '{
        9'd0,   9'd31,  9'd61,  9'd92,  9'd122, 9'd153,
        9'd184, 9'd214, 9'd245, 9'd275, 9'd306, 9'd337
    };

    // Pipeline control handed to the back conversion.
    typedef struct packed {
        logic adv;
        logic valid;
    } cdo_ctrl_t;

    // Result of the back conversion; year is offset by one era (400 years).
    typedef struct packed {
        logic        valid;
        logic [14:0] year_full;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [2:0]  weekday;
        logic        reiwa;
    } cdo_civil_t;

endpackage

// ----- rtl/cdo_from_days.sv -----
// Seven-stage pipeline that turns an internal day count back into a civil date.
module cdo_from_days (
    input  logic                      clk,
    input  logic                      rst_n,
    input  cdo_pkg::cdo_ctrl_t        ctrl,
    input  logic [cdo_pkg::DAY_W-1:0] days,
    output cdo_pkg::cdo_civil_t       civil
);
    import cdo_pkg::*;

    logic [6:0] valid_reg;

    // Stage 1: era estimate and weekday quotient.
    logic [37:0]      era_prod;
    logic [23:0]      days_p3;
    logic [47:0]      week_prod;
    logic [DAY_W-1:0] days1_reg;
    logic [5:0]       era1_reg;
    logic [19:0]      q7_reg;

    // Stage 2: remainder within the era, weekday, era flag.
    logic [22:0] rem_full;
    logic [23:0] wd_full;
    logic [18:0] rem2_reg;
    logic [5:0]  era2_reg;
    logic [2:0]  wd2_reg;
    logic        reiwa2_reg;

    // Stage 3: corrected day of era.
    logic [17:0] doe_next;
    logic [5:0]  era_next;
    logic [17:0] doe3_reg;
    logic [5:0]  era3_reg;
    logic [2:0]  wd3_reg;
    logic        reiwa3_reg;

    // Stage 4: leap-corrected day count.
    logic [35:0] q1460_prod;
    logic [2:0]  q36524;
    logic        era_last;
    logic [17:0] t4_reg;
    logic [17:0] doe4_reg;
    logic [5:0]  era4_reg;
    logic [2:0]  wd4_reg;
    logic        reiwa4_reg;

    // Stage 5: year of era.
    logic [35:0] yoe_prod;
    logic [8:0]  yoe5_reg;
    logic [17:0] doe5_reg;
    logic [5:0]  era5_reg;
    logic [2:0]  wd5_reg;
    logic        reiwa5_reg;

    // Stage 6: day of year.
    logic [1:0]  cent;
    logic [17:0] doy_full;
    logic [8:0]  doy6_reg;
    logic [8:0]  yoe6_reg;
    logic [5:0]  era6_reg;
    logic [2:0]  wd6_reg;
    logic        reiwa6_reg;

    // Stage 7: month, day and full year.
    logic [3:0]  mp;
    logic [8:0]  day_full;
    logic [3:0]  month_next;
    logic [14:0] year_next;
    logic [14:0] year7_reg;
    logic [3:0]  month7_reg;
    logic [4:0]  day7_reg;
    logic [2:0]  wd7_reg;
    logic        reiwa7_reg;

    always_comb
    begin
        era_prod  = 38'(days) * 38'(ERA_RECIP);
        days_p3   = 24'(days) + 24'd3;
        week_prod = 48'(days_p3) * 48'(WEEK_RECIP);

        rem_full = 23'(days1_reg) - 23'(era1_reg) * 23'(ERA_DAYS);
        wd_full  = (24'(days1_reg) + 24'd3) - 24'(q7_reg) * 24'd7;

        if (rem2_reg >= 19'(ERA_DAYS))
        begin
            doe_next = 18'(rem2_reg - 19'(ERA_DAYS));
            era_next = era2_reg + 6'd1;
        end
        else
        begin
            doe_next = rem2_reg[17:0];
            era_next = era2_reg;
        end

        q1460_prod = 36'(doe3_reg) * 36'(Q1460_RECIP);
        q36524 = 3'(doe3_reg >= 18'd36524) + 3'(doe3_reg >= 18'd73048)
               + 3'(doe3_reg >= 18'd109572) + 3'(doe3_reg >= 18'd146096);
        era_last = (doe3_reg == 18'd146096);

        yoe_prod = 36'(t4_reg) * 36'(YEAR_RECIP);

        cent = 2'(yoe5_reg >= 9'd100) + 2'(yoe5_reg >= 9'd200) + 2'(yoe5_reg >= 9'd300);
        doy_full = doe5_reg - (18'(yoe5_reg) * 18'd365 + 18'(yoe5_reg[8:2]) - 18'(cent));

        mp = 4'd0;
        for (int k = 1; k < 12; k++)
        begin
            mp = mp + 4'(doy6_reg >= MONTH_START[k]);
        end
        day_full   = doy6_reg - MONTH_START[mp] + 9'd1;
        month_next = (mp < 4'd10) ? mp + 4'd3 : mp - 4'd9;
        year_next  = 15'(yoe6_reg) + 15'(era6_reg) * 15'd400 + 15'(month_next <= 4'd2);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (ctrl.adv)
        begin
            valid_reg <= {valid_reg[5:0], ctrl.valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.adv)
        begin
            days1_reg  <= days;
            era1_reg   <= era_prod[37:32];
            q7_reg     <= week_prod[45:26];

            rem2_reg   <= rem_full[18:0];
            era2_reg   <= era1_reg;
            wd2_reg    <= wd_full[2:0];
            reiwa2_reg <= (days1_reg >= REIWA_DAY);

            doe3_reg   <= doe_next;
            era3_reg   <= era_next;
            wd3_reg    <= wd2_reg;
            reiwa3_reg <= reiwa2_reg;

            t4_reg     <= doe3_reg - 18'(q1460_prod[34:28]) + 18'(q36524) - 18'(era_last);
            doe4_reg   <= doe3_reg;
            era4_reg   <= era3_reg;
            wd4_reg    <= wd3_reg;
            reiwa4_reg <= reiwa3_reg;

            yoe5_reg   <= yoe_prod[34:26];
            doe5_reg   <= doe4_reg;
            era5_reg   <= era4_reg;
            wd5_reg    <= wd4_reg;
            reiwa5_reg <= reiwa4_reg;

            doy6_reg   <= doy_full[8:0];
            yoe6_reg   <= yoe5_reg;
            era6_reg   <= era5_reg;
            wd6_reg    <= wd5_reg;
            reiwa6_reg <= reiwa5_reg;

            year7_reg  <= year_next;
            month7_reg <= month_next;
            day7_reg   <= day_full[4:0];
            wd7_reg    <= wd6_reg;
            reiwa7_reg <= reiwa6_reg;
        end
    end

    assign civil.valid     = valid_reg[6];
    assign civil.year_full = year7_reg;
    assign civil.month     = month7_reg;
    assign civil.day       = day7_reg;
    assign civil.weekday   = wd7_reg;
    assign civil.reiwa     = reiwa7_reg;

endmodule

// ----- rtl/civil_date_offset.sv -----
// Top level of the civil date offset block: shifts a Gregorian date by a day count.
//
// Channel   Dir  Signals                     Contents
// s_*       in   tvalid tready tdata[39:0]   start date and signed day offset
// m_*       out  tvalid tready tdata[47:0]   shifted date, weekday, Reiwa year, error
//
// Every transfer goes through ten register stages: two that build a day count,
// seven in the back conversion and the output register.
// One input transfer is taken in every cycle unless the output is stalled;
// the single pipeline enable sets that rate.
// Reset clears only the valid bits; the data registers are left as they are.
// While m_tready is low and a result waits, the whole pipeline holds and s_tready is low.
module civil_date_offset (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    // Fields from bit 0: in_year[13:0], in_month[3:0], in_day[4:0], day_offset[15:0].
    input  logic [cdo_pkg::IN_W-1:0]  s_tdata,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    // Fields from bit 0: out_year[13:0], out_month[3:0], out_day[4:0], weekday[2:0],
    // era_valid, era_year[12:0], range_error.
    output logic [cdo_pkg::OUT_W-1:0] m_tdata
);
    import cdo_pkg::*;

    // The whole pipeline moves together when the output can take a result.
    logic adv;

    logic [13:0]        in_year;
    logic [3:0]         in_month;
    logic [4:0]         in_day;
    logic [15:0]        day_offset;

    // Stage 1: the year is shifted back for January and February (the
    // calendar here starts in March) and forward by one era so it never
    // goes negative; the century quotient comes from a reciprocal multiply.
    logic               leap_shift;
    logic [14:0]        yp_next;
    logic [25:0]        q100_prod;
    logic               s1_valid_reg;
    logic [14:0]        yp_reg;
    logic [7:0]         q100_reg;
    logic [8:0]         bd_reg;
    logic [15:0]        off_reg;

    // Stage 2: internal day count, 365 days a year plus the leap days, plus the signed day offset.
    logic [24:0]        day_sum;
    logic               s2_valid_reg;
    logic [DAY_W-1:0]   days_reg;

    cdo_ctrl_t          ctrl;
    cdo_civil_t         civil;

    // Output stage.
    logic               range_err;
    logic [14:0]        year_sub;
    logic [13:0]        era_sub;
    logic               m_tvalid_reg;
    logic [OUT_W-1:0]   m_tdata_reg;

    assign adv      = !m_tvalid_reg || m_tready;
    assign s_tready = adv;

    assign in_year    = s_tdata[13:0];
    assign in_month   = s_tdata[17:14];
    assign in_day     = s_tdata[22:18];
    assign day_offset = s_tdata[38:23];

    always_comb
    begin
        leap_shift = (in_month <= 4'd2);
        yp_next    = 15'(in_year) + 15'd400 - 15'(leap_shift);
        q100_prod  = 26'(yp_next[14:2]) * 26'(Q25_RECIP);

        day_sum = 25'd365 * 25'(yp_reg) + 25'(yp_reg[14:2]) - 25'(q100_reg)
                + 25'(q100_reg[7:2]) + 25'(bd_reg) - 25'd1
                + {{9{off_reg[15]}}, off_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= s_tvalid;
            s2_valid_reg <= s1_valid_reg;
            m_tvalid_reg <= civil.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            yp_reg   <= yp_next;
            q100_reg <= q100_prod[24:17];
            bd_reg   <= MONTH_BASE[in_month] + 9'(in_day);
            off_reg  <= day_offset;
            days_reg <= day_sum[DAY_W-1:0];
        end
    end

    assign ctrl.adv   = adv;
    assign ctrl.valid = s2_valid_reg;

    cdo_from_days u_from_days (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (ctrl),
        .days  (days_reg),
        .civil (civil)
    );

    // The back conversion gives the year one era high; remove it, then test
    // the range and derive the Reiwa year.
    always_comb
    begin
        range_err = (civil.year_full < 15'd400) || (civil.year_full > 15'd10399);
        year_sub  = civil.year_full - 15'd400;
        era_sub   = year_sub[13:0] - 14'd2018;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (range_err)
            begin
                m_tdata_reg <= {7'd0, 1'b1, 40'd0};
            end
            else
            begin
                m_tdata_reg <= {7'd0, 1'b0,
                                civil.reiwa ? era_sub[12:0] : 13'd0,
                                civil.reiwa,
                                civil.weekday,
                                civil.day,
                                civil.month,
                                year_sub[13:0]};
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // A range error clears every other result field.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[40]) |-> (m_tdata[39:0] == 40'd0))
        else $error("range error result carries nonzero fields");

    // A Reiwa date has a Reiwa year that matches the Gregorian year.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[26]) |-> (m_tdata[39:27] == 13'(m_tdata[13:0] - 14'd2018)))
        else $error("Reiwa year does not match the shifted year");

    // A valid date has a real month, a real day and a real weekday.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tdata[40]) |->
            (m_tdata[17:14] != 4'd0 && m_tdata[17:14] <= 4'd12 &&
             m_tdata[22:18] != 5'd0 && m_tdata[25:23] <= 3'd6))
        else $error("shifted date out of calendar bounds");

    // A result held for a stall keeps the rest of the pipeline from moving.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> ($stable(days_reg) && $stable(s2_valid_reg)))
        else $error("pipeline moved while the output was stalled");

endmodule
